### rtl/alws_pkg.sv
// ============================================================================
// alws_pkg
// Shared types, constants and lane decode for the write slave.
// ============================================================================
`default_nettype none

package alws_pkg;

    localparam int ADDR_WIDTH = 32;

    // Latched address keeps only the low ADDR_WIDTH bits (all 32 when wider)
    localparam logic [31:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

    localparam logic [3:0] LANES_B0   = 4'h1;
    localparam logic [3:0] LANES_B1   = 4'h2;
    localparam logic [3:0] LANES_B2   = 4'h4;
    localparam logic [3:0] LANES_B3   = 4'h8;
    localparam logic [3:0] LANES_LO   = 4'h3;
    localparam logic [3:0] LANES_HI   = 4'hC;
    localparam logic [3:0] LANES_WORD = 4'hF;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_WAIT_AW = 3'd1,
        PH_ACK_AW  = 3'd2,
        PH_WAIT_W  = 3'd3,
        PH_ACK_W   = 3'd4,
        PH_WAIT_B  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_STROBE = 2'd1,
        ERR_ALIGN  = 2'd2
    } err_t;

    typedef struct packed {
        logic        aw_valid;
        logic [31:0] aw_address;
        logic        w_valid;
        logic [31:0] w_payload;
        logic [3:0]  w_lanes;
        logic        b_ready;
    } step_t;

    typedef struct packed {
        logic        aw_ready;
        logic        w_ready;
        logic        b_valid;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] mem_payload;
        logic [3:0]  mem_lanes;
        logic [1:0]  write_error;
    } result_t;

    typedef struct packed {
        logic       bad;
        logic [1:0] offset;
    } lane_dec_t;

    function automatic lane_dec_t lane_decode(input logic [3:0] lanes);
        lane_dec_t d;
        d.bad    = 1'b0;
        d.offset = 2'd0;
        case (lanes)
            LANES_B0:   d.offset = 2'd0;
            LANES_B1:   d.offset = 2'd1;
            LANES_B2:   d.offset = 2'd2;
            LANES_B3:   d.offset = 2'd3;
            LANES_LO:   d.offset = 2'd0;
            LANES_HI:   d.offset = 2'd2;
            LANES_WORD: d.offset = 2'd0;
            default:    d.bad    = 1'b1;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/alws_step_if.sv
// ============================================================================
// alws_step_if
// Channel carrying one sampled bus word per clock into the slave while ready is high.
// ============================================================================
`default_nettype none

interface alws_step_if;
    logic                 valid;
    logic                 ready;
    alws_pkg::step_t      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/alws_result_if.sv
// ============================================================================
// alws_result_if
// Channel carrying one result word per accepted step.
// ============================================================================
`default_nettype none

interface alws_result_if;
    logic                 valid;
    logic                 ready;
    alws_pkg::result_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/alws_ctrl.sv
// ============================================================================
// alws_ctrl
// Six-phase write handshake machine, address/data latches and write decode.
// ============================================================================
`default_nettype none

module alws_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire alws_pkg::step_t   item,
    output alws_pkg::result_t      res
);

    alws_pkg::phase_t  phase_reg,   phase_next;
    logic [31:0]       address_reg, address_next;
    logic [31:0]       payload_reg, payload_next;
    logic [3:0]        lanes_reg,   lanes_next;

    alws_pkg::lane_dec_t dec;
    alws_pkg::err_t      err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= alws_pkg::PH_IDLE;
            address_reg <= '0;
            payload_reg <= '0;
            lanes_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            address_reg <= address_next;
            payload_reg <= payload_next;
            lanes_reg   <= lanes_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        address_next = address_reg;
        payload_next = payload_reg;
        lanes_next   = lanes_reg;
        case (phase_reg)
            alws_pkg::PH_WAIT_AW:
            begin
                if (item.aw_valid)
                begin
                    address_next = item.aw_address & alws_pkg::ADDR_MASK;
                    phase_next   = alws_pkg::PH_ACK_AW;
                end
            end
            alws_pkg::PH_ACK_AW:
            begin
                if (!item.aw_valid)
                    phase_next = alws_pkg::PH_WAIT_W;
            end
            alws_pkg::PH_WAIT_W:
            begin
                if (item.w_valid)
                begin
                    payload_next = item.w_payload;
                    lanes_next   = item.w_lanes;
                    phase_next   = alws_pkg::PH_ACK_W;
                end
            end
            alws_pkg::PH_ACK_W:
            begin
                if (!item.w_valid)
                    phase_next = alws_pkg::PH_WAIT_B;
            end
            alws_pkg::PH_WAIT_B:
            begin
                if (item.b_ready)
                    phase_next = alws_pkg::PH_IDLE;
            end
            default:
                phase_next = alws_pkg::PH_WAIT_AW;
        endcase
    end

    // strobe decode; a bad strobe outranks misalignment
    always_comb
    begin
        dec = alws_pkg::lane_decode(lanes_reg);
        if (dec.bad)
            err = alws_pkg::ERR_STROBE;
        else if (address_reg[1:0] != 2'b00)
            err = alws_pkg::ERR_ALIGN;
        else
            err = alws_pkg::ERR_NONE;
    end

    // outputs: handshake levels follow the phase after this word
    always_comb
    begin
        res          = '0;
        res.aw_ready = (phase_next == alws_pkg::PH_ACK_AW);
        res.w_ready  = (phase_next == alws_pkg::PH_ACK_W);
        res.b_valid  = (phase_next == alws_pkg::PH_WAIT_B);
        if (phase_reg == alws_pkg::PH_ACK_W && !item.w_valid)
        begin
            res.mem_address = address_reg;
            res.mem_payload = payload_reg >> {dec.offset, 3'b000};
            res.mem_lanes   = lanes_reg;
            res.write_error = err;
            res.mem_write   = (err == alws_pkg::ERR_NONE);
        end
    end

endmodule

`default_nettype wire

### rtl/alws_out_stage.sv
// ============================================================================
// alws_out_stage
// Result register; takes a new word whenever it is empty or being drained.
// ============================================================================
`default_nettype none

module alws_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_valid,
    input  wire alws_pkg::result_t load_data,
    output logic                   load_ready,
    alws_result_if.source          result
);

    logic              valid_reg,  valid_next;
    alws_pkg::result_t data_reg,   data_next;

    assign load_ready = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load_ready)
        begin
            valid_next = load_valid;
            data_next  = load_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result.valid = valid_reg;
    assign result.data  = data_reg;

endmodule

`default_nettype wire

### rtl/axi_lite_write_slave.sv
// ============================================================================
// axi_lite_write_slave
// Clock-sampled AXI4-Lite write slave issuing one memory write per error-free transfer.
// ============================================================================
//
//  channel  dir  modport  contents
//  -------  ---  -------  ---------------------------------------------------
//  step     in   sink     aw/w/b bus levels sampled for one clock
//  result   out  source   aw_ready, w_ready, b_valid, memory write, error
//
//  One word per cycle unless stalled: phase machine and write decode sit
//  between the phase and latch registers and the result register.
//  Reset puts the machine in idle and empties the result register.
//  The step channel stalls only while a held result is not being taken.
//
`default_nettype none

module axi_lite_write_slave (
    input  wire logic      clk,
    input  wire logic      rst_n,
    alws_step_if.sink      step,
    alws_result_if.source  result
);

    alws_pkg::result_t res;
    logic              load_ready;
    logic              accept;

    assign step.ready = load_ready;
    assign accept     = step.valid && load_ready;

    alws_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (step.data),
        .res    (res)
    );

    alws_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (step.valid),
        .load_data  (res),
        .load_ready (load_ready),
        .result     (result)
    );

endmodule

`default_nettype wire
